FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: hdl/usbmidi_pkg.sv
package usbmidi_pkg;

   // item kinds on the request channel
   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [1:0] OP_SYSEX    = 2'd2;

   // code index numbers
   localparam logic [3:0] CIN_NOTE_ON  = 4'h9;
   localparam logic [3:0] CIN_NOTE_OFF = 4'h8;
   localparam logic [3:0] CIN_SX_MORE  = 4'h4;
   localparam logic [3:0] CIN_SX_END1  = 4'h5;
   localparam logic [3:0] CIN_SX_END2  = 4'h6;
   localparam logic [3:0] CIN_SX_END3  = 4'h7;

   localparam logic [7:0] STATUS_ON  = 8'h90;
   localparam logic [7:0] STATUS_OFF = 8'h80;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] cable;
      logic [3:0] channel;
      logic [7:0] note;
      logic [7:0] velocity;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] header;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_NOTE_ON,
      CMD_NOTE_OFF,
      CMD_SYSEX
   } cmd_kind_type;

   // classified item; byte_a is the status byte for notes, the data byte for SysEx
   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   cable;
      logic [7:0]   byte_a;
      logic [6:0]   note;
      logic [6:0]   velocity;
      logic         last;
   } cmd_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
      logic                   full;
   } q_status_type;

endpackage

FILE: hdl/usbmidi_front.sv
module usbmidi_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  usbmidi_pkg::req_type req_payload,
   output logic                 push_valid,
   input  logic                 push_ready,
   output usbmidi_pkg::cmd_type push_cmd
);

   logic known_op;

   // unknown op is taken and dropped here
   assign req_ready  = push_ready;
   assign push_valid = req_valid && known_op;

   always_comb begin
      known_op          = 1'b1;
      push_cmd.cable    = req_payload.cable;
      push_cmd.note     = req_payload.note[6:0];
      push_cmd.velocity = req_payload.velocity[6:0];
      push_cmd.last     = req_payload.last;
      case (req_payload.op)
         usbmidi_pkg::OP_NOTE_ON: begin
            push_cmd.kind   = usbmidi_pkg::CMD_NOTE_ON;
            push_cmd.byte_a = usbmidi_pkg::STATUS_ON | {4'h0, req_payload.channel};
         end
         usbmidi_pkg::OP_NOTE_OFF: begin
            push_cmd.kind   = usbmidi_pkg::CMD_NOTE_OFF;
            push_cmd.byte_a = usbmidi_pkg::STATUS_OFF | {4'h0, req_payload.channel};
         end
         usbmidi_pkg::OP_SYSEX: begin
            push_cmd.kind   = usbmidi_pkg::CMD_SYSEX;
            push_cmd.byte_a = req_payload.data_byte;
         end
         default: begin
            known_op        = 1'b0;
            push_cmd.kind   = usbmidi_pkg::CMD_SYSEX;
            push_cmd.byte_a = req_payload.data_byte;
         end
      endcase
   end

endmodule

FILE: hdl/usbmidi_queue.sv
module usbmidi_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  usbmidi_pkg::cmd_type      push_cmd,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output usbmidi_pkg::cmd_type      pop_cmd,
   output usbmidi_pkg::q_status_type status
);

   localparam logic [usbmidi_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      usbmidi_pkg::QUEUE_PTR_W'(usbmidi_pkg::QUEUE_DEPTH - 1);
   localparam logic [usbmidi_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      usbmidi_pkg::QUEUE_CNT_W'(usbmidi_pkg::QUEUE_DEPTH);

   usbmidi_pkg::cmd_type mem_ff [usbmidi_pkg::QUEUE_DEPTH];
   logic [usbmidi_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [usbmidi_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [usbmidi_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready   = (count_ff != CNT_FULL);
   assign pop_valid    = (count_ff != '0);
   assign pop_cmd      = mem_ff[rd_ptr_ff];
   assign push         = push_valid && push_ready;
   assign pop          = pop_valid && pop_ready;
   assign status.count = count_ff;
   assign status.full  = !push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hdl/usbmidi_back.sv
module usbmidi_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  usbmidi_pkg::cmd_type cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output usbmidi_pkg::rsp_type rsp_payload
);

   logic [7:0] held_ff [2];
   logic [7:0] held_in [2];
   logic [1:0] held_count_ff, held_count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   usbmidi_pkg::rsp_type rsp_ff, pkt;
   logic       take, emit;

   assign cmd_ready   = !rsp_valid_ff || rsp_ready;
   assign take        = cmd_valid && cmd_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      emit          = 1'b1;
      held_in       = held_ff;
      held_count_in = held_count_ff;
      pkt.header    = {cmd.cable, usbmidi_pkg::CIN_NOTE_ON};
      pkt.byte_one  = cmd.byte_a;
      pkt.byte_two  = {1'b0, cmd.note};
      pkt.byte_three = {1'b0, cmd.velocity};
      case (cmd.kind)
         usbmidi_pkg::CMD_NOTE_ON: begin
         end
         usbmidi_pkg::CMD_NOTE_OFF: begin
            pkt.header     = {cmd.cable, usbmidi_pkg::CIN_NOTE_OFF};
            pkt.byte_three = 8'h00;
         end
         usbmidi_pkg::CMD_SYSEX: begin
            if (held_count_ff == 2'd2) begin
               pkt.header = {cmd.cable, cmd.last ? usbmidi_pkg::CIN_SX_END3
                                                 : usbmidi_pkg::CIN_SX_MORE};
               pkt.byte_one   = held_ff[0];
               pkt.byte_two   = held_ff[1];
               pkt.byte_three = cmd.byte_a;
               held_count_in  = 2'd0;
            end else if (cmd.last) begin
               if (held_count_ff == 2'd1) begin
                  pkt.header   = {cmd.cable, usbmidi_pkg::CIN_SX_END2};
                  pkt.byte_one = held_ff[0];
                  pkt.byte_two = cmd.byte_a;
               end else begin
                  pkt.header   = {cmd.cable, usbmidi_pkg::CIN_SX_END1};
                  pkt.byte_one = cmd.byte_a;
                  pkt.byte_two = 8'h00;
               end
               pkt.byte_three = 8'h00;
               held_count_in  = 2'd0;
            end else begin
               // hold the byte, nothing to send yet
               emit                       = 1'b0;
               held_in[held_count_ff[0]]  = cmd.byte_a;
               held_count_in              = held_count_ff + 2'd1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         held_count_ff <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            held_count_ff <= held_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         held_ff <= held_in;
      end
      if (take && emit) begin
         rsp_ff <= pkt;
      end
   end

endmodule

FILE: hdl/usb_midi_event_packetizer.sv
// USB-MIDI event packetizer. Each request transfer carries a note-on, a
// note-off or one SysEx byte; each response transfer is one 4-byte USB-MIDI
// event packet (header = cable:CIN, then three payload bytes, unused ones
// zero). Note items always give one packet. SysEx bytes are gathered three
// to a packet (CIN 4), and a byte flagged last closes the message with CIN
// 7, 6 or 5; the header cable is that of the closing byte. Up to two SysEx
// bytes wait inside and stay put across note items. A last byte with
// nothing held goes out alone under CIN 5. Op 3 items give no packet.
// Throughput is one request per clock, with packets leaving one per clock
// while the response side takes them; once the queue is full, req_ready
// drops. A request transfer reaches rsp_valid through the two-entry command
// queue after the decoder and then the packet builder's output register. The
// queue lets requests keep flowing for up to two more transfers while the
// response side stalls.
`include "assert_macros.svh"

module usb_midi_event_packetizer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  usbmidi_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output usbmidi_pkg::rsp_type rsp_payload
);

   logic                      push_valid, push_ready;
   logic                      pop_valid, pop_ready;
   usbmidi_pkg::cmd_type      push_cmd, pop_cmd;
   usbmidi_pkg::q_status_type q_status;

   // decode and classify; drops unknown ops
   usbmidi_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   // decouples the decoder from the packet builder
   usbmidi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .status     (q_status)
   );

   // SysEx gathering and packet output register
   usbmidi_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (pop_valid),
      .cmd_ready   (pop_ready),
      .cmd         (pop_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // queue never over fills
   `ASSERT_IMPLIES(a_queue_bound, clock, reset, 1'b1,
      q_status.count <= usbmidi_pkg::QUEUE_CNT_W'(usbmidi_pkg::QUEUE_DEPTH))

   // a note transfer is in the queue or already at the output in the next cycle
   `ASSERT_NEXT(a_note_in_flight, clock, reset,
      req_valid && req_ready && (req_payload.op == usbmidi_pkg::OP_NOTE_ON ||
      req_payload.op == usbmidi_pkg::OP_NOTE_OFF),
      q_status.count != '0 || rsp_valid)

   // an empty queue with an idle output produces no packet next cycle
   `ASSERT_NEXT(a_no_phantom, clock, reset,
      q_status.count == '0 && !rsp_valid, !rsp_valid)

endmodule

FILE: test/tb_usb_midi_event_packetizer.sv
module tb_usb_midi_event_packetizer;
   timeunit 1ns;
   timeprecision 1ps;

   // op code 3 has no meaning: the block must swallow it without a packet
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Watchdog, in clock cycles.
   localparam int CYCLE_LIMIT = 200000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   usbmidi_pkg::req_type req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   usbmidi_pkg::rsp_type rsp_payload;

   usb_midi_event_packetizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Shadow of the SysEx bytes the block is holding back.
   logic [7:0] sx_held [2];
   logic [1:0] sx_count;

   // Packets the block still owes us, oldest first.
   usbmidi_pkg::rsp_type pending_packets [$];

   string packet_fields [4] = '{"header", "byte_one", "byte_two", "byte_three"};

   // Idling controls, set by the tests.
   bit req_gaps_on     = 1'b0;
   bit rsp_stalls_on   = 1'b0;
   int rsp_hold_cycles = 0;

   int items_sent   = 0;
   int packets_seen = 0;
   int input_stalls = 0;
   int error_count  = 0;
   int cycle_count  = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: only reached if the run hangs.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d packets still owed",
               $time, cycle_count, pending_packets.size());
      $display("tb_usb_midi_event_packetizer: done, errors");
      $finish;
   end

   // Expected packet for one accepted request transfer. Note items always give
   // a packet; SysEx bytes are held until a third byte or a last flag closes
   // a packet, and the closing byte's cable goes in the header.
   function automatic void build_packet(input usbmidi_pkg::req_type item);
      usbmidi_pkg::rsp_type pkt;
      bit                   emit;
      pkt  = '0;
      emit = 1'b1;
      case (item.op)
         usbmidi_pkg::OP_NOTE_ON: begin
            pkt.header     = {item.cable, usbmidi_pkg::CIN_NOTE_ON};
            pkt.byte_one   = usbmidi_pkg::STATUS_ON | {4'h0, item.channel};
            pkt.byte_two   = {1'b0, item.note[6:0]};
            pkt.byte_three = {1'b0, item.velocity[6:0]};
         end
         usbmidi_pkg::OP_NOTE_OFF: begin
            pkt.header   = {item.cable, usbmidi_pkg::CIN_NOTE_OFF};
            pkt.byte_one = usbmidi_pkg::STATUS_OFF | {4'h0, item.channel};
            pkt.byte_two = {1'b0, item.note[6:0]};
         end
         usbmidi_pkg::OP_SYSEX: begin
            if (sx_count == 2'd2) begin
               pkt.header     = {item.cable, (item.last ? usbmidi_pkg::CIN_SX_END3
                                                        : usbmidi_pkg::CIN_SX_MORE)};
               pkt.byte_one   = sx_held[0];
               pkt.byte_two   = sx_held[1];
               pkt.byte_three = item.data_byte;
               sx_count       = 2'd0;
            end else if (item.last) begin
               if (sx_count == 2'd1) begin
                  pkt.header   = {item.cable, usbmidi_pkg::CIN_SX_END2};
                  pkt.byte_one = sx_held[0];
                  pkt.byte_two = item.data_byte;
               end else begin
                  // single-byte message, nothing held
                  pkt.header   = {item.cable, usbmidi_pkg::CIN_SX_END1};
                  pkt.byte_one = item.data_byte;
               end
               sx_count = 2'd0;
            end else begin
               sx_held[sx_count[0]] = item.data_byte;
               sx_count             = sx_count + 2'd1;
               emit                 = 1'b0;
            end
         end
         default: emit = 1'b0;
      endcase
      if (emit)
         pending_packets.push_back(pkt);
   endfunction

   // One request transfer. An optional idle burst comes first; valid is then
   // held with a steady payload until the transfer happens.
   task automatic send_item(input usbmidi_pkg::req_type item);
      int gap;
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) begin
         input_stalls++;
         @(posedge clock);
      end
      build_packet(item);
      items_sent++;
   endtask

   function automatic usbmidi_pkg::req_type make_item(
         input logic [1:0] op, input logic [3:0] cable,
         input logic [3:0] channel, input logic [7:0] note,
         input logic [7:0] velocity,
         input logic [7:0] data_byte, input logic last);
      usbmidi_pkg::req_type item;
      item.op        = op;
      item.cable     = cable;
      item.channel   = channel;
      item.note      = note;
      item.velocity  = velocity;
      item.data_byte = data_byte;
      item.last      = last;
      return item;
   endfunction

   // Random content in every field, including the ones the op ignores.
   function automatic usbmidi_pkg::req_type any_item(input logic [1:0] op,
                                                     input logic last);
      return make_item(op, 4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), last);
   endfunction

   function automatic logic [1:0] any_note_op();
      return ($urandom_range(0, 1) != 0) ? usbmidi_pkg::OP_NOTE_OFF
                                         : usbmidi_pkg::OP_NOTE_ON;
   endfunction

   // SysEx message of len bytes, now and then with a note slipped in between
   // bytes. An unclosed message just runs into the next one.
   task automatic send_sysex_message(input int len, input bit closed);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_item(any_item(any_note_op(), 1'($urandom)));
         send_item(any_item(usbmidi_pkg::OP_SYSEX, closed && (i == len - 1)));
      end
   endtask

   // Response side: random stall bursts, or one long hold on request.
   initial begin : response_side
      int n;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Every response transfer is checked against the oldest owed packet.
   always @(posedge clock) begin : packet_check
      usbmidi_pkg::rsp_type want;
      logic [31:0]          want_bits;
      logic [31:0]          got_bits;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         packets_seen++;
         if (pending_packets.size() == 0) begin
            error_count++;
            $display("%0t: packet %h arrived with none expected", $time, rsp_payload);
         end else begin
            want      = pending_packets.pop_front();
            want_bits = want;
            got_bits  = rsp_payload;
            for (int i = 0; i < 4; i++) begin
               if (got_bits[31 - 8 * i -: 8] !== want_bits[31 - 8 * i -: 8]) begin
                  error_count++;
                  $display("%0t: %s mismatch, expected %h, got %h", $time,
                           packet_fields[i], want_bits[31 - 8 * i -: 8],
                           got_bits[31 - 8 * i -: 8]);
               end
            end
         end
      end
   end

   // Status byte, 7-bit masking of note and velocity, cable and channel extremes.
   task automatic test_note_extremes();
      send_item(make_item(usbmidi_pkg::OP_NOTE_ON, 4'h0, 4'h0, 8'h00, 8'h00, 8'hFF, 1'b1));
      send_item(make_item(usbmidi_pkg::OP_NOTE_ON, 4'hF, 4'hF, 8'hFF, 8'hFF, 8'h00, 1'b0));
      send_item(make_item(usbmidi_pkg::OP_NOTE_OFF, 4'hF, 4'h0, 8'h7F, 8'hFF, 8'h55, 1'b1));
      send_item(make_item(usbmidi_pkg::OP_NOTE_OFF, 4'h0, 4'hF, 8'h80, 8'h7F, 8'hAA, 1'b0));
   endtask

   // Messages of one to four bytes: every closing code plus the three-byte
   // continuation. In the longer messages the closing cable differs from the opening one.
   task automatic test_sysex_lengths();
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'h3, 4'h0, 8'h00, 8'h00, 8'hF0, 1'b1));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'h0, 4'hF, 8'hFF, 8'hFF, 8'hF0, 1'b0));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'hF, 4'h0, 8'h00, 8'h00, 8'hF7, 1'b1));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'h5, 4'h1, 8'h12, 8'h34, 8'hF0, 1'b0));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'h6, 4'h2, 8'h56, 8'h78, 8'h00, 1'b0));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'h7, 4'h3, 8'h9A, 8'hBC, 8'hF7, 1'b1));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'hA, 4'h4, 8'h00, 8'h00, 8'hF0, 1'b0));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'hB, 4'h5, 8'h00, 8'h00, 8'hFF, 1'b0));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'hC, 4'h6, 8'h00, 8'h00, 8'h7E, 1'b0));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'hD, 4'h7, 8'h00, 8'h00, 8'hF7, 1'b1));
   endtask

   // Notes go out at once while SysEx bytes stay held around them.
   task automatic test_note_inside_sysex();
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'h1, 4'h0, 8'h00, 8'h00, 8'hF0, 1'b0));
      send_item(make_item(usbmidi_pkg::OP_NOTE_ON, 4'h2, 4'h9, 8'h3C, 8'h64, 8'h00, 1'b1));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'h1, 4'h0, 8'h00, 8'h00, 8'h41, 1'b0));
      send_item(make_item(usbmidi_pkg::OP_NOTE_OFF, 4'h4, 4'h9, 8'h3C, 8'h40, 8'hFF, 1'b1));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'h9, 4'h0, 8'h00, 8'h00, 8'hF7, 1'b1));
   endtask

   // Op 3 gives nothing and must not disturb a message in progress.
   task automatic test_unknown_op();
      send_item(make_item(OP_UNUSED, 4'hF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'h8, 4'h0, 8'h00, 8'h00, 8'hF0, 1'b0));
      send_item(make_item(OP_UNUSED, 4'h0, 4'h0, 8'h00, 8'h00, 8'h00, 1'b1));
      send_item(make_item(usbmidi_pkg::OP_SYSEX, 4'h8, 4'h0, 8'h00, 8'h00, 8'hF7, 1'b1));
   endtask

   // Mostly well-formed SysEx messages with random content, plus loose notes,
   // unclosed messages and op 3 noise. Idling switches on and off in stretches.
   task automatic test_random_mix(input int target);
      int stop_at;
      int pick;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 19) == 0) begin
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 9);
         if (pick < 6)
            send_sysex_message($urandom_range(1, 8), $urandom_range(0, 9) != 0);
         else if (pick < 9)
            send_item(any_item(any_note_op(), 1'($urandom)));
         else
            send_item(any_item(OP_UNUSED, 1'($urandom)));
      end
   endtask

   // Long hold on the response side while requests keep coming back to back,
   // so the queue fills and req_ready drops.
   task automatic test_backpressure();
      req_gaps_on     = 1'b0;
      rsp_stalls_on   = 1'b0;
      rsp_hold_cycles = 80;
      for (int i = 0; i < 24; i++) begin
         if (i % 3 == 2)
            send_item(any_item(usbmidi_pkg::OP_SYSEX, 1'b1));
         else
            send_item(any_item(any_note_op(), 1'($urandom)));
      end
   endtask

   // Final stretch at full rate on both sides.
   task automatic test_full_rate(input int count);
      int stop_at;
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 2) == 0)
            send_item(any_item(any_note_op(), 1'($urandom)));
         else
            send_sysex_message($urandom_range(1, 7), 1'b1);
      end
   endtask

   initial begin : main
      sx_held[0] = 8'h00;
      sx_held[1] = 8'h00;
      sx_count   = 2'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_note_extremes();
      test_sysex_lengths();
      test_note_inside_sysex();
      test_unknown_op();

      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
      test_random_mix(450);
      test_backpressure();
      test_full_rate(100);

      req_valid <= 1'b0;
      while (pending_packets.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("run: %0d request transfers, %0d packets checked, %0d stalled request cycles",
               items_sent, packets_seen, input_stalls);
      $display("run: note extremes, SysEx closes of 1-3 bytes, notes inside messages, "
               , "op 3 noise, long response hold, full-rate tail");
      if (error_count == 0) begin
         $display("tb_usb_midi_event_packetizer: done, clean");
      end else begin
         $display("tb_usb_midi_event_packetizer: done, errors");
      end
      $finish;
   end

endmodule
